// ----- hdl/tsag_pkg.sv -----
// Shared constants and types for the tensor slice address generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tsag_pkg;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 48;
  localparam int ND_W         = 3;
  localparam int NUM_CFG_DIMS = 4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_NUM_DIMS   = 3'd0;
  localparam cfg_idx_t REG_DIM0_SLICE = 3'd1;
endpackage
`default_nettype wire

// ----- hdl/tsag_ifs.sv -----
// Channel interfaces: input item, result item and configuration write.
// Depends on tsag_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface tsag_in_if #(parameter int OFFSET_BITS = 31);
  logic                   valid;
  logic                   ready;
  logic [OFFSET_BITS-1:0] out_offset;
  modport source (output valid, output out_offset, input ready);
  modport sink   (input valid, input out_offset, output ready);
endinterface

interface tsag_out_if #(parameter int OFFSET_BITS = 31);
  logic                   valid;
  logic                   ready;
  logic [OFFSET_BITS-1:0] src_offset;
  logic                   beyond_end;
  modport source (output valid, output src_offset, output beyond_end, input ready);
  modport sink   (input valid, input src_offset, input beyond_end, output ready);
endinterface

interface tsag_cfg_if;
  logic                            valid;
  logic                            ready;
  tsag_pkg::cfg_idx_t              index;
  logic [tsag_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/tsag_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tsag_div #(
  parameter int W  = 31,
  parameter int DW = 16,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [W-1:0]  dividend,
  input  wire logic [DW-1:0] divisor,
  input  wire logic [SW-1:0] side_in,
  output logic               out_valid,
  output logic [W-1:0]       quot,
  output logic [DW-1:0]      rem,
  output logic [SW-1:0]      side_out
);
  logic          v_r  [0:W];
  logic [W-1:0]  dq_r [0:W];
  logic [DW-1:0] r_r  [0:W];
  logic [SW-1:0] sd_r [0:W];

  always_comb begin
    v_r[0]  = in_valid;
    dq_r[0] = dividend;
    r_r[0]  = '0;
    sd_r[0] = side_in;
  end

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [DW:0] rr;
    logic        ge;
    logic [DW:0] rn;
    always_comb begin
      rr = {r_r[k], dq_r[k][W-1]};
      ge = rr >= {1'b0, divisor};
      rn = ge ? rr - {1'b0, divisor} : rr;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
      if (en) begin
        r_r[k+1]  <= rn[DW-1:0];
        dq_r[k+1] <= {dq_r[k][W-2:0], ge};
        sd_r[k+1] <= sd_r[k];
      end
    end
  end

  assign out_valid = v_r[W];
  assign quot      = dq_r[W];
  assign rem       = r_r[W];
  assign side_out  = sd_r[W];
endmodule
`default_nettype wire

// ----- hdl/tensor_slice_address_generator.sv -----
// Top level: slice offset to source offset mapping pipeline.
// Depends on tsag_pkg, tsag_ifs and tsag_div.
//
//  channel | dir | fields                      | handshake
//  in_ch   | in  | out_offset                  | valid/ready
//  out_ch  | out | src_offset, beyond_end      | valid/ready
//  cfg_ch  | in  | index, data                 | valid/ready (ready always 1)
//
// One item per cycle while the output is not stalled. The accepting edge loads the input
// register; behind it sit one divider stage per quotient bit per dimension, one
// recombine stage per dimension, then the output register. A stalled output freezes
// the whole pipeline; nothing is dropped. Reset clears valid bits and loads the
// register defaults; bound decode and element count are rebuilt through registers
// after a configuration write.
`timescale 1ns / 1ps
`default_nettype none
module tensor_slice_address_generator #(
  parameter int MAX_DIMS    = 4,
  parameter int DIM_BITS    = 16,
  parameter int OFFSET_BITS = 31
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tsag_in_if.sink   in_ch,
  tsag_out_if.source out_ch,
  tsag_cfg_if.sink  cfg_ch
);
  localparam int DB  = DIM_BITS;
  localparam int OB  = OFFSET_BITS;
  localparam int EXW = 3 * DB + tsag_pkg::CFG_DATA_W;
  localparam int SW  = OB + MAX_DIMS * DB;
  localparam logic [OB:0] CAP = {1'b1, {OB{1'b0}}};

  // ---------------- configuration registers
  logic [tsag_pkg::ND_W-1:0]       nd_r;
  logic [tsag_pkg::CFG_DATA_W-1:0] dim_r [MAX_DIMS];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nd_r <= tsag_pkg::ND_W'(1);
      for (int i = 0; i < MAX_DIMS; i++) dim_r[i] <= tsag_pkg::CFG_DATA_W'(1);
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == tsag_pkg::REG_NUM_DIMS) begin
        nd_r <= cfg_ch.data[tsag_pkg::ND_W-1:0];
      end
      for (int i = 0; i < MAX_DIMS; i++) begin
        if (i < tsag_pkg::NUM_CFG_DIMS &&
            cfg_ch.index == tsag_pkg::cfg_idx_t'(i + 1)) begin
          dim_r[i] <= cfg_ch.data;
        end
      end
    end
  end

  // ---------------- bound decode, one register level
  function automatic logic [DB-1:0] clamp_bound(input logic signed [DB-1:0] b,
                                                 input logic [DB-1:0] sz);
    logic signed [DB+1:0] t;
    logic signed [DB+1:0] szs;
    szs = $signed({2'b00, sz});
    t   = (DB+2)'(b);
    if (t < 0) t = t + szs;
    if (t < 0) t = '0;
    else if (t > szs) t = szs;
    return t[DB-1:0];
  endfunction

  logic [DB-1:0] size_r  [MAX_DIMS];
  logic [DB-1:0] start_r [MAX_DIMS];
  logic [DB-1:0] len_r   [MAX_DIMS];
  logic [OB:0]   cnt_r   [0:MAX_DIMS];

  assign cnt_r[0] = (OB+1)'(1);

  for (genvar i = 0; i < MAX_DIMS; i++) begin : g_dim
    logic [EXW-1:0] ext;
    logic [DB-1:0]  sz, s, e;
    logic           used;
    logic [OB+DB:0] prod;
    always_comb begin
      ext  = {{(3*DB){1'b0}}, dim_r[i]};
      sz   = ext[DB-1:0];
      s    = clamp_bound($signed(ext[2*DB-1:DB]), sz);
      e    = clamp_bound($signed(ext[3*DB-1:2*DB]), sz);
      used = (i == 0) || (tsag_pkg::ND_W'(i) < nd_r);
      prod = cnt_r[i] * len_r[i];
    end
    always_ff @(posedge clk) begin
      size_r[i]  <= used ? sz : DB'(1);
      start_r[i] <= used ? s  : '0;
      len_r[i]   <= used ? ((e > s) ? e - s : '0) : DB'(1);
      cnt_r[i+1] <= (prod > (OB+DB+1)'(CAP)) ? CAP : prod[OB:0];
    end
  end

  // ---------------- input register
  logic adv;
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  logic          dv_a  [0:MAX_DIMS];
  logic [OB-1:0] dq_a  [0:MAX_DIMS];
  logic [SW-1:0] dsd_a [0:MAX_DIMS];
  logic          in_v_r;
  logic [OB-1:0] in_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (adv) begin
      in_v_r <= in_ch.valid;
    end
    if (adv) in_off_r <= in_ch.out_offset;
  end

  always_comb begin
    dv_a[0]  = in_v_r;
    dq_a[0]  = in_off_r;
    dsd_a[0] = {in_off_r, {(MAX_DIMS*DB){1'b0}}};
  end

  // ---------------- digit extraction, innermost dimension first
  for (genvar j = 0; j < MAX_DIMS; j++) begin : g_div
    localparam int D = MAX_DIMS - 1 - j;
    logic [DB-1:0] rem;
    logic [SW-1:0] sd;
    tsag_div #(.W(OB), .DW(DB), .SW(SW)) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_valid (dv_a[j]),
      .dividend (dq_a[j]),
      .divisor  (len_r[D]),
      .side_in  (dsd_a[j]),
      .out_valid(dv_a[j+1]),
      .quot     (dq_a[j+1]),
      .rem      (rem),
      .side_out (sd)
    );
    always_comb begin
      dsd_a[j+1]               = sd;
      dsd_a[j+1][D*DB +: DB]   = rem;
    end
  end

  // ---------------- recombine with source sizes, outermost first
  logic          rv_a   [0:MAX_DIMS];
  logic [OB-1:0] racc_a [0:MAX_DIMS];
  logic [SW-1:0] rsd_a  [0:MAX_DIMS];

  always_comb begin
    rv_a[0]   = dv_a[MAX_DIMS];
    racc_a[0] = '0;
    rsd_a[0]  = dsd_a[MAX_DIMS];
  end

  for (genvar m = 0; m < MAX_DIMS; m++) begin : g_rc
    logic [OB+DB-1:0] prod;
    logic [OB-1:0]    acc_nxt;
    always_comb begin
      prod    = racc_a[m] * size_r[m];
      acc_nxt = prod[OB-1:0] + OB'(start_r[m]) + OB'(rsd_a[m][m*DB +: DB]);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rv_a[m+1] <= 1'b0;
      end else if (adv) begin
        rv_a[m+1] <= rv_a[m];
      end
      if (adv) begin
        racc_a[m+1] <= acc_nxt;
        rsd_a[m+1]  <= rsd_a[m];
      end
    end
  end

  // ---------------- range check and output register
  logic          out_v_r;
  logic [OB-1:0] out_src_r;
  logic          out_be_r;
  logic          beyond;

  assign beyond = {1'b0, rsd_a[MAX_DIMS][SW-1 -: OB]} >= cnt_r[MAX_DIMS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= rv_a[MAX_DIMS];
    end
    if (adv) begin
      out_be_r  <= beyond;
      out_src_r <= beyond ? '0 : racc_a[MAX_DIMS];
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.src_offset = out_src_r;
  assign out_ch.beyond_end = out_be_r;

  // ---------------- checks
  a_beyond_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.beyond_end |-> out_ch.src_offset == '0)
    else $error("beyond_end item with nonzero source offset");

  a_empty_slice: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && cnt_r[MAX_DIMS] == '0 |-> out_ch.beyond_end)
    else $error("empty slice produced an in-range item");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while output stalled");
endmodule
`default_nettype wire

// ----- tb/sv/tensor_slice_address_generator_tb.sv -----
// Self-checking testbench for tensor_slice_address_generator: directed and random offsets
// under several slice settings, checked against an in-bench mapping predictor.
// Depends on tsag_pkg, tsag_ifs and the RTL top level.
`timescale 1ns / 1ps
module tensor_slice_address_generator_tb;
  localparam int MAX_DIMS    = 4;
  localparam int DIM_BITS    = 16;
  localparam int OFFSET_BITS = 31;
  localparam int LATENCY     = MAX_DIMS * OFFSET_BITS + MAX_DIMS + 2;
  localparam int WATCHDOG    = 20000;
  localparam longint COUNT_CAP = 64'd1 << OFFSET_BITS;
  // index past the last register; a write there changes nothing
  localparam tsag_pkg::cfg_idx_t UNMAPPED_IDX = 3'd5;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] src_offset;
    logic                   beyond_end;
  } addr_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tsag_in_if  #(.OFFSET_BITS(OFFSET_BITS)) in_ch ();
  tsag_out_if #(.OFFSET_BITS(OFFSET_BITS)) out_ch ();
  tsag_cfg_if cfg_ch ();

  tensor_slice_address_generator #(
    .MAX_DIMS(MAX_DIMS), .DIM_BITS(DIM_BITS), .OFFSET_BITS(OFFSET_BITS)
  ) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #4 clk = ~clk;

  // predictor copy of the registers
  logic [2:0]                      num_dims_q;
  logic [tsag_pkg::CFG_DATA_W-1:0] dim_slice_q [MAX_DIMS];

  addr_result_t expected_addrs[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  long_hold = 1'b0;
  bit  stall_mode = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.out_offset = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = tsag_pkg::REG_NUM_DIMS;
    cfg_ch.data = '0;
  end

  function automatic longint clamp_bound(longint b, longint sz);
    if (b < 0) b += sz;
    if (b < 0) b = 0;
    if (b > sz) b = sz;
    return b;
  endfunction

  function automatic addr_result_t map_offset(logic [OFFSET_BITS-1:0] off);
    addr_result_t r;
    longint sz [MAX_DIMS];
    longint st [MAX_DIMS];
    longint ln [MAX_DIMS];
    longint digit [MAX_DIMS];
    longint count, rem, acc, s, e;
    int nd;
    nd = num_dims_q;
    if (nd == 0) nd = 1;
    if (nd > MAX_DIMS) nd = MAX_DIMS;
    count = 1;
    for (int i = 0; i < MAX_DIMS; i++) begin
      if (i < nd) begin
        sz[i] = dim_slice_q[i][DIM_BITS-1:0];
        s = clamp_bound(longint'($signed(dim_slice_q[i][2*DIM_BITS-1:DIM_BITS])), sz[i]);
        e = clamp_bound(longint'($signed(dim_slice_q[i][3*DIM_BITS-1:2*DIM_BITS])), sz[i]);
        st[i] = s;
        ln[i] = (e > s) ? e - s : 0;
      end else begin
        sz[i] = 1; st[i] = 0; ln[i] = 1;
      end
      count = count * ln[i];
      if (count > COUNT_CAP) count = COUNT_CAP;
    end
    if (longint'(off) >= count) begin
      r.src_offset = '0;
      r.beyond_end = 1'b1;
      return r;
    end
    rem = off;
    for (int i = MAX_DIMS - 1; i >= 0; i--) begin
      digit[i] = rem % ln[i];
      rem = rem / ln[i];
    end
    acc = 0;
    for (int i = 0; i < MAX_DIMS; i++)
      acc = acc * sz[i] + st[i] + digit[i];
    r.src_offset = acc[OFFSET_BITS-1:0];
    r.beyond_end = 1'b0;
    return r;
  endfunction

  function automatic tsag_pkg::cfg_idx_t dim_reg(int i);
    return tsag_pkg::cfg_idx_t'(int'(tsag_pkg::REG_DIM0_SLICE) + i);
  endfunction

  task automatic write_reg(tsag_pkg::cfg_idx_t idx, logic [tsag_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == tsag_pkg::REG_NUM_DIMS)
      num_dims_q = value[2:0];
    else if (idx <= tsag_pkg::NUM_CFG_DIMS)
      dim_slice_q[idx - tsag_pkg::REG_DIM0_SLICE] = value;
    @(posedge clk);
  endtask

  function automatic logic [tsag_pkg::CFG_DATA_W-1:0] pack_dim(int sz, int st, int en);
    return {en[15:0], st[15:0], sz[15:0]};
  endfunction

  // sender burst state
  int burst_left = 0;

  // valid stays up between items of a burst; drain() or a gap drops it
  task automatic send_offset(logic [OFFSET_BITS-1:0] off, bit paced);
    int gap;
    if (paced) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    in_ch.valid <= 1'b1;
    in_ch.out_offset <= off;
    do @(posedge clk); while (!in_ch.ready);
    expected_addrs.push_back(map_offset(off));
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_ch.valid <= 1'b0;
    while (expected_addrs.size() != 0 && n < WATCHDOG * 4) begin
      @(posedge clk);
      n++;
    end
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic logic [OFFSET_BITS-1:0] rand_offset(longint count);
    case ($urandom_range(0, 9))
      0: return OFFSET_BITS'({$urandom, $urandom});
      1: return count[OFFSET_BITS-1:0];
      default: return (count > 0) ? OFFSET_BITS'(longint'($urandom) % count)
                                  : OFFSET_BITS'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic longint slice_count();
    longint c;
    c = 1;
    for (int i = 0; i < MAX_DIMS; i++) begin
      longint sz, s, e;
      if (i < ((num_dims_q == 0) ? 1 : (num_dims_q > MAX_DIMS ? MAX_DIMS : num_dims_q))) begin
        sz = dim_slice_q[i][DIM_BITS-1:0];
        s = clamp_bound(longint'($signed(dim_slice_q[i][2*DIM_BITS-1:DIM_BITS])), sz);
        e = clamp_bound(longint'($signed(dim_slice_q[i][3*DIM_BITS-1:2*DIM_BITS])), sz);
        c = c * ((e > s) ? e - s : 0);
        if (c > COUNT_CAP) c = COUNT_CAP;
      end
    end
    return c;
  endfunction

  task automatic test_reset_defaults();
    // reset slice is empty: every offset is past the end
    send_offset('0, 1'b0);
    send_offset({OFFSET_BITS{1'b1}}, 1'b0);
    drain();
  endtask

  task automatic test_directed_slices();
    write_reg(tsag_pkg::REG_NUM_DIMS, 48'd3);
    write_reg(dim_reg(0), pack_dim(5, 1, 4));
    write_reg(dim_reg(1), pack_dim(7, -5, -1));
    write_reg(dim_reg(2), pack_dim(9, -100, 100));
    write_reg(dim_reg(3), pack_dim(3, 2, 1));
    for (int i = 0; i < 8; i++) send_offset(OFFSET_BITS'(i * 7), 1'b0);
    send_offset(OFFSET_BITS'(3 * 4 * 9 - 1), 1'b0);
    send_offset(OFFSET_BITS'(3 * 4 * 9), 1'b0);
    drain();
    // out-of-range dim count and a wrapping source
    write_reg(tsag_pkg::REG_NUM_DIMS, 48'd0);
    send_offset('0, 1'b0);
    drain();
    write_reg(tsag_pkg::REG_NUM_DIMS, 48'd7);
    for (int i = 0; i < 4; i++)
      write_reg(dim_reg(i), pack_dim(16'hffff, 16'h7fff, -1));
    send_offset('0, 1'b0);
    send_offset(OFFSET_BITS'(12345), 1'b0);
    drain();
    // saturating count, empty slice
    for (int i = 0; i < 4; i++)
      write_reg(dim_reg(i), pack_dim(16'hffff, 0, 16'h7fff));
    send_offset({OFFSET_BITS{1'b1}}, 1'b0);
    send_offset(31'h2aaa_aaaa, 1'b0);
    drain();
    write_reg(UNMAPPED_IDX, 48'hffff_ffff_ffff);
    send_offset(31'h2aaa_aaaa, 1'b0);
    drain();
    write_reg(dim_reg(1), pack_dim(0, -1, 5));
    send_offset('0, 1'b0);
    drain();
  endtask

  task automatic test_random_slices();
    for (int phase = 0; phase < 12; phase++) begin
      longint cnt;
      write_reg(tsag_pkg::REG_NUM_DIMS, tsag_pkg::CFG_DATA_W'($urandom_range(0, 7)));
      for (int i = 0; i < 4; i++) begin
        if (phase % 4 == 3)
          write_reg(dim_reg(i), tsag_pkg::CFG_DATA_W'({$urandom, $urandom}));
        else begin
          int sz;
          sz = (phase == 11) ? $urandom_range(40000, 65535) : $urandom_range(0, 12);
          write_reg(dim_reg(i),
                    pack_dim(sz, $urandom_range(0, 20) - 10, $urandom_range(0, 20) - 10));
        end
      end
      cnt = slice_count();
      if (phase == 5) long_hold = 1'b1;
      // the hold-off phase sends past the pipeline depth so the input backs up
      for (int k = 0; k < ((phase == 5) ? 200 : 62); k++)
        send_offset(rand_offset(cnt), 1'b1);
      drain();
    end
  endtask

  // receiver: stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (long_hold) begin
      out_ch.ready <= 1'b0;
      repeat (LATENCY * 2) @(posedge clk);
      long_hold = 1'b0;
    end else if ($urandom_range(0, 63) == 0)
      stall_mode = ~stall_mode;
    if (!long_hold)
      out_ch.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
  end

  // result checker
  always @(posedge clk) begin
    addr_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_addrs.size() == 0) begin
        $error("unexpected item: src_offset %0h", out_ch.src_offset);
        errors++;
      end else begin
        exp_r = expected_addrs.pop_front();
        if (out_ch.src_offset !== exp_r.src_offset) begin
          $error("src_offset expected %0h actual %0h", exp_r.src_offset, out_ch.src_offset);
          errors++;
        end
        if (out_ch.beyond_end !== exp_r.beyond_end) begin
          $error("beyond_end expected %0b actual %0b", exp_r.beyond_end, out_ch.beyond_end);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else if (expected_addrs.size() != 0 || in_ch.valid || cfg_ch.valid)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    num_dims_q = 3'd1;
    for (int i = 0; i < MAX_DIMS; i++) dim_slice_q[i] = 48'd1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (MAX_DIMS + 4) @(posedge clk);
    test_reset_defaults();
    test_directed_slices();
    test_random_slices();
    if (errors == 0 && expected_addrs.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
